[hw/rtl/afd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// afd_pkg
// Shared constants, command and status types for the fall detector.
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam int unsigned VarLen   = 30;
  localparam int unsigned ArmCount = 40;
  localparam int unsigned PostLen  = 35;

  localparam int unsigned PtrW  = $clog2(VarLen);
  localparam int unsigned ArmW  = $clog2(ArmCount + 1);
  localparam int unsigned PostW = $clog2(PostLen + 1);

  localparam logic [15:0] RestMag = 16'd2511;

  localparam logic [7:0] ProbClass0 = 8'd241;
  localparam logic [7:0] ProbClass1 = 8'd210;
  localparam logic [7:0] ProbClass2 = 8'd64;
  localparam logic [7:0] ProbClass3 = 8'd26;

  localparam logic [1:0] ClassFreefallImpactStill = 2'd0;
  localparam logic [1:0] ClassImpactStill         = 2'd1;
  localparam logic [1:0] ClassImpactMoving        = 2'd2;
  localparam logic [1:0] ClassOther               = 2'd3;

  localparam logic [2:0] RegFreefall  = 3'd0;
  localparam logic [2:0] RegImpact    = 3'd1;
  localparam logic [2:0] RegSevere    = 3'd2;
  localparam logic [2:0] RegStillVar  = 3'd3;
  localparam logic [2:0] RegThreshold = 3'd4;

  typedef struct packed {
    logic [15:0] freefall_limit;
    logic [15:0] impact_limit;
    logic [15:0] severe_impact_limit;
    logic [31:0] still_variance_limit;
    logic [7:0]  fall_prob_threshold;
  } cfg_t;

  typedef struct packed {
    logic [15:0] accel_x;
    logic [15:0] accel_y;
    logic [15:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic decision_valid;
    logic fall_detected;
    logic [1:0] fall_class;
    logic [7:0] fall_prob;
    logic [15:0] peak_magnitude;
    logic [15:0] min_magnitude;
    logic candidate_open;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture sample, start squaring
    logic sq_step;  // accumulate one axis square
    logic rt_init;  // start square root
    logic rt_step;  // one root iteration
    logic rt_fin;   // rounding
    logic hist_rd;  // fetch old history entry
    logic upd;      // update sums, history, window state
    logic mul_a;    // n * sumsq
    logic mul_b;    // sum * sum
    logic decide;   // classify and close window
    logic cancel;   // clear window
    logic emit;     // load the output register
  } afd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic close_win;  // this sample closes the window
  } afd_sts_t;

endpackage
`default_nettype wire

[hw/rtl/afd_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// afd_stream_if
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface afd_stream_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/afd_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// afd_datapath
// Magnitude (iterative squaring and root), history, sums and window tracking.
// ----------------------------------------------------------------------------
module afd_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire afd_pkg::cfg_t     cfg_i,
  input  wire afd_pkg::sample_t  sample_i,
  input  wire afd_pkg::afd_cmd_t cmd_i,
  output afd_pkg::afd_sts_t      sts_o,
  output afd_pkg::result_t       result_o
);

  logic [15:0] ax_q, ay_q, az_q;
  logic [15:0] ax_d, ay_d, az_d;
  logic [1:0]  axis_q;
  logic [33:0] sq_acc_q;
  logic [31:0] rem_q, res_q, bit_q;
  logic [15:0] mag_q;
  logic [15:0] hist_mem [afd_pkg::VarLen];
  logic [15:0] old_q;
  logic        filled_q;
  logic [afd_pkg::PtrW-1:0] ptr_q;
  logic [20:0] sum_q;
  logic [36:0] sumsq_q;
  logic [afd_pkg::ArmW-1:0] seen_q;
  logic        win_q;
  logic [afd_pkg::PostW-1:0] post_q;
  logic [15:0] peak_q, min_q;
  logic [42:0] prod_a_q;
  logic [41:0] prod_b_q;
  logic        close_q;
  afd_pkg::result_t res_out_q;
  afd_pkg::result_t res_next;
  afd_pkg::result_t out_q;

  function automatic logic [15:0] abs16(input logic [15:0] v);
    abs16 = v[15] ? 16'(-v) : v;
  endfunction

  assign ax_d = abs16(sample_i.accel_x);
  assign ay_d = abs16(sample_i.accel_y);
  assign az_d = abs16(sample_i.accel_z);

  // Squaring: one axis a cycle through a single 16x16 multiplier
  logic [15:0] sq_op;
  logic [31:0] sq_prod;
  always_comb begin
    case (axis_q)
      2'd0:    sq_op = ax_q;
      2'd1:    sq_op = ay_q;
      default: sq_op = az_q;
    endcase
  end
  assign sq_prod = sq_op * sq_op;

  // Root iteration (sum fits in 32 bits: max 3*2^30)
  logic [31:0] rt_trial;
  assign rt_trial = res_q + bit_q;

  // Update
  logic [15:0] mag_new;
  logic [31:0] mag_sq;
  logic [31:0] old_sq;
  logic [20:0] sum_new;
  logic [36:0] sumsq_new;
  logic        armed_after;
  logic [afd_pkg::ArmW-1:0] seen_new;
  assign mag_new  = mag_q;
  assign mag_sq   = mag_q * mag_q;
  assign old_sq   = old_q * old_q;
  assign sum_new  = sum_q - 21'(old_q) + 21'(mag_q);
  assign sumsq_new = sumsq_q - 37'(old_sq) + 37'(mag_sq);
  assign seen_new = (seen_q < afd_pkg::ArmW'(afd_pkg::ArmCount)) ?
                    seen_q + 1'b1 : seen_q;
  assign armed_after = (seen_new >= afd_pkg::ArmW'(afd_pkg::ArmCount));

  // Decision
  logic [42:0] spread;
  logic [42:0] lim_scaled;
  logic        still, freefall, severe;
  logic [1:0]  cls;
  logic [7:0]  prob;
  assign spread     = (prod_a_q > 43'(prod_b_q)) ? prod_a_q - 43'(prod_b_q) : '0;
  assign lim_scaled = 43'(cfg_i.still_variance_limit) *
                      43'(afd_pkg::VarLen * afd_pkg::VarLen);
  assign still      = spread < lim_scaled;
  assign freefall   = min_q < cfg_i.freefall_limit;
  assign severe     = peak_q > cfg_i.severe_impact_limit;
  always_comb begin
    if (freefall && severe && still) begin
      cls = afd_pkg::ClassFreefallImpactStill; prob = afd_pkg::ProbClass0;
    end else if (severe && still) begin
      cls = afd_pkg::ClassImpactStill; prob = afd_pkg::ProbClass1;
    end else if (severe) begin
      cls = afd_pkg::ClassImpactMoving; prob = afd_pkg::ProbClass2;
    end else begin
      cls = afd_pkg::ClassOther; prob = afd_pkg::ProbClass3;
    end
  end

  // Entries ahead of the pointer read as zero until it first wraps
  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_rd) old_q <= filled_q ? hist_mem[ptr_q] : '0;
    if (cmd_i.upd) hist_mem[ptr_q] <= mag_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q      <= '0;
      ay_q      <= '0;
      az_q      <= '0;
      sq_acc_q  <= '0;
      rem_q     <= '0;
      res_q     <= '0;
      bit_q     <= '0;
      mag_q     <= '0;
      prod_a_q  <= '0;
      prod_b_q  <= '0;
      filled_q  <= 1'b0;
      ptr_q     <= '0;
      sum_q     <= '0;
      sumsq_q   <= '0;
      seen_q    <= '0;
      win_q     <= 1'b0;
      post_q    <= '0;
      peak_q    <= afd_pkg::RestMag;
      min_q     <= afd_pkg::RestMag;
      close_q   <= 1'b0;
      axis_q    <= '0;
      res_out_q <= '0;
      out_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        ax_q <= ax_d; ay_q <= ay_d; az_q <= az_d;
        axis_q   <= '0;
        sq_acc_q <= '0;
      end
      if (cmd_i.sq_step) begin
        sq_acc_q <= sq_acc_q + 34'(sq_prod);
        axis_q   <= axis_q + 1'b1;
      end
      if (cmd_i.rt_init) begin
        rem_q <= sq_acc_q[31:0];
        res_q <= '0;
        bit_q <= 32'h4000_0000;
      end
      if (cmd_i.rt_step) begin
        if (bit_q != '0) begin
          if (rem_q >= rt_trial) begin
            rem_q <= rem_q - rt_trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      end
      if (cmd_i.rt_fin) begin
        mag_q <= (rem_q > res_q) ? 16'(res_q + 1'b1) : res_q[15:0];
      end
      if (cmd_i.upd) begin
        sum_q   <= sum_new;
        sumsq_q <= sumsq_new;
        ptr_q   <= (ptr_q == afd_pkg::PtrW'(afd_pkg::VarLen - 1)) ? '0 : ptr_q + 1'b1;
        if (ptr_q == afd_pkg::PtrW'(afd_pkg::VarLen - 1)) filled_q <= 1'b1;
        seen_q  <= seen_new;
        close_q <= armed_after && win_q &&
                   (post_q + 1'b1 >= afd_pkg::PostW'(afd_pkg::PostLen));
        res_out_q.decision_valid <= 1'b0;
        res_out_q.fall_detected  <= 1'b0;
        res_out_q.fall_class     <= '0;
        res_out_q.fall_prob      <= '0;
        if (armed_after) begin
          if (!win_q) begin
            if (mag_new < cfg_i.freefall_limit || mag_new > cfg_i.impact_limit) begin
              win_q  <= 1'b1;
              post_q <= '0;
              peak_q <= mag_new;
              min_q  <= mag_new;
            end
          end else begin
            if (mag_new > peak_q) peak_q <= mag_new;
            if (mag_new < min_q) min_q <= mag_new;
            post_q <= post_q + 1'b1;
          end
        end
      end
      if (cmd_i.mul_a) prod_a_q <= 43'(sumsq_q) * 43'(afd_pkg::VarLen);
      if (cmd_i.mul_b) prod_b_q <= sum_q * sum_q;
      if (cmd_i.decide) begin
        res_out_q.decision_valid <= 1'b1;
        res_out_q.fall_class     <= cls;
        res_out_q.fall_prob      <= prob;
        res_out_q.fall_detected  <= (prob >= cfg_i.fall_prob_threshold);
        win_q <= 1'b0;
      end
      if (cmd_i.cancel) begin
        win_q  <= 1'b0;
        post_q <= '0;
        peak_q <= afd_pkg::RestMag;
        min_q  <= afd_pkg::RestMag;
        res_out_q.decision_valid <= 1'b0;
        res_out_q.fall_detected  <= 1'b0;
        res_out_q.fall_class     <= '0;
        res_out_q.fall_prob      <= '0;
      end
      // Hold the finished transaction here so the next one may start
      if (cmd_i.emit) out_q <= res_next;
    end
  end

  assign sts_o.close_win = close_q;

  always_comb begin
    res_next                = res_out_q;
    res_next.peak_magnitude = peak_q;
    res_next.min_magnitude  = min_q;
    res_next.candidate_open = win_q;
  end

  assign result_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> win_q)
    else $error("decision without open window");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cancel |=> !win_q && peak_q == afd_pkg::RestMag)
    else $error("cancel did not clear window");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_q |-> min_q <= peak_q)
    else $error("window min above peak");

endmodule
`default_nettype wire

[hw/rtl/afd_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// afd_controller
// Sequences one transaction through the datapath and drives the handshake.
// ----------------------------------------------------------------------------
module afd_controller (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         in_func_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire afd_pkg::afd_sts_t sts_i,
  output afd_pkg::afd_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StSquare, StRootInit, StRoot, StRootFin, StRead, StUpdate,
    StMulA, StMulB, StDecide, StOut
  } state_e;

  state_e state_q;
  logic [3:0] cnt_q;
  logic out_valid_q;
  logic emit;

  // Load the output register once the previous result has gone
  assign emit = (state_q == StOut) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            if (in_func_i) begin
              state_q <= StOut;
            end else begin
              state_q <= StSquare;
              cnt_q   <= '0;
            end
          end
        end
        StSquare: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'd2) state_q <= StRootInit;
        end
        StRootInit: begin
          state_q <= StRoot;
          cnt_q   <= '0;
        end
        StRoot: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'd15) state_q <= StRootFin;
        end
        StRootFin: state_q <= StRead;
        StRead:    state_q <= StUpdate;
        StUpdate:  state_q <= StMulA;
        StMulA:    state_q <= sts_i.close_win ? StMulB : StOut;
        StMulB:    state_q <= StDecide;
        StDecide:  state_q <= StOut;
        StOut: begin
          if (emit) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // The output register parts the two sides: accept while a result waits.
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == StIdle) && in_valid_i && in_ready_o && !in_func_i;
    cmd_o.cancel  = (state_q == StIdle) && in_valid_i && in_ready_o && in_func_i;
    cmd_o.sq_step = (state_q == StSquare);
    cmd_o.rt_init = (state_q == StRootInit);
    cmd_o.rt_step = (state_q == StRoot);
    cmd_o.rt_fin  = (state_q == StRootFin);
    cmd_o.hist_rd = (state_q == StRead);
    cmd_o.upd     = (state_q == StUpdate);
    cmd_o.mul_a   = (state_q == StMulA);
    cmd_o.mul_b   = (state_q == StMulB);
    cmd_o.decide  = (state_q == StDecide);
    cmd_o.emit    = emit;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd |=> state_q == StMulA)
    else $error("update not followed by variance product");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.cancel, cmd_o.upd, cmd_o.decide}))
    else $error("conflicting commands");

endmodule
`default_nettype wire

[hw/rtl/accel_fall_detector.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// accel_fall_detector
// Accelerometer magnitude, variance and threshold fall classifier.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_if    in   func, accel_x, accel_y, accel_z
// out_if   out  decision_valid .. candidate_open (one result per item)
// cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i (5 registers)
//
// A sample passes from acceptance through squaring on one multiplier, root
// set-up, the bit-pair square root, rounding, history read, update, the
// first variance product and the output load, then returns to idle.
// Closing a window adds the second product and the decision before the
// output load. A cancel item goes straight to the output load. One item is
// in flight at a time; the next is accepted while the previous result waits
// in the output register, and an item holds in its last state until that
// register is free.
// Reset is asynchronous; history entries read as zero until the pointer
// first wraps.
// ----------------------------------------------------------------------------
module accel_fall_detector (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  afd_stream_if.sink      in_if,
  afd_stream_if.source    out_if,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);

  afd_pkg::cfg_t     cfg_q;
  afd_pkg::afd_cmd_t cmd;
  afd_pkg::afd_sts_t sts;
  afd_pkg::result_t  result;
  afd_pkg::sample_t  sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.freefall_limit       <= 16'd1536;
      cfg_q.impact_limit         <= 16'd5632;
      cfg_q.severe_impact_limit  <= 16'd5888;
      cfg_q.still_variance_limit <= 32'd294912;
      cfg_q.fall_prob_threshold  <= 8'd205;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        afd_pkg::RegFreefall:  cfg_q.freefall_limit       <= cfg_wdata_i[15:0];
        afd_pkg::RegImpact:    cfg_q.impact_limit         <= cfg_wdata_i[15:0];
        afd_pkg::RegSevere:    cfg_q.severe_impact_limit  <= cfg_wdata_i[15:0];
        afd_pkg::RegStillVar:  cfg_q.still_variance_limit <= cfg_wdata_i;
        afd_pkg::RegThreshold: cfg_q.fall_prob_threshold  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign sample.accel_x = in_if.data[47:32];
  assign sample.accel_y = in_if.data[31:16];
  assign sample.accel_z = in_if.data[15:0];

  afd_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_func_i   (in_if.data[48]),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  afd_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .sample_i (sample),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result)
  );

  assign out_if.data = result;

endmodule
`default_nettype wire
